[rtl/vqg_pkg.sv]
// Shared types, constants and helpers for the four-value group decoder.
// No dependencies; compiled first.
package vqg_pkg;

	localparam int NUM_LANES = 4;
	localparam int WORD_W    = 32;
	localparam int WIN_BYTES = 16;
	localparam int WIN_W     = WIN_BYTES * 8;
	localparam int LEN_W     = 3;
	localparam int OFF_W     = $clog2(WIN_BYTES);
	localparam int BYTES_W   = 5;
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [OFF_W-1:0]   off_t;
	typedef logic [BYTES_W-1:0] bytes_t;
	typedef logic [NUM_LANES-1:0][WORD_W-1:0] lane_vec_t;

	// Register index map of the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH_MODE = 2'd0,
		CFG_ZIGZAG      = 2'd1,
		CFG_DELTA       = 2'd2,
		CFG_DELTA_START = 2'd3
	} cfg_idx_t;

	// Length modes
	localparam logic MODE_1234 = 1'b0;
	localparam logic MODE_0124 = 1'b1;

	typedef struct packed {
		logic  length_mode;
		logic  zigzag_enable;
		logic  delta_enable;
		word_t delta_start;
	} cfg_t;

	// One decoded group on its way from the lanes to the merge stage
	typedef struct packed {
		lane_vec_t vals;
		bytes_t    bytes_used;
		logic      restart;
	} grp_t;

	// Byte count of one value from its 2-bit length code
	function automatic len_t byte_count(input logic mode, input logic [1:0] code);
		len_t n;
		if (mode == MODE_0124) begin
			case (code)
				2'd0:    n = 3'd0;
				2'd1:    n = 3'd1;
				2'd2:    n = 3'd2;
				default: n = 3'd4;
			endcase
		end else begin
			n = len_t'(code) + 3'd1;
		end
		return n;
	endfunction

endpackage

[rtl/vqg_in_if.sv]
// Input channel of the group decoder: key byte, 16-byte window, restart flag.
// Depends on nothing.
interface vqg_in_if;
	logic         valid;
	logic         ready;
	logic [7:0]   key_byte;
	logic [63:0]  data_low;
	logic [63:0]  data_high;
	logic         restart;

	modport source (output valid, key_byte, data_low, data_high, restart, input ready);
	modport sink   (input valid, key_byte, data_low, data_high, restart, output ready);
endinterface

[rtl/vqg_out_if.sv]
// Output channel of the group decoder: four values and the bytes consumed.
// Depends on nothing.
interface vqg_out_if;
	logic         valid;
	logic         ready;
	logic [31:0]  value0;
	logic [31:0]  value1;
	logic [31:0]  value2;
	logic [31:0]  value3;
	logic [4:0]   bytes_used;

	modport source (output valid, value0, value1, value2, value3, bytes_used, input ready);
	modport sink   (input valid, value0, value1, value2, value3, bytes_used, output ready);
endinterface

[rtl/vqg_lane.sv]
// One decode lane: picks up to four bytes at an offset of the window,
// assembles them little-endian and applies the optional zigzag step.
// Depends on vqg_pkg.
module vqg_lane
	import vqg_pkg::*;
(
	input  logic [WIN_W-1:0] window,
	input  off_t             offset,
	input  len_t             len,
	input  logic             zigzag_enable,
	output word_t            value
);

	word_t raw;

	always_comb begin
		off_t idx;
		raw = '0;
		for (int b = 0; b < 4; b++) begin
			idx = offset + off_t'(b);
			if (len > len_t'(b))
				raw[8*b +: 8] = window[8*idx +: 8];
		end
	end

	// zigzag: (v >> 1) ^ -(v & 1)
	assign value = zigzag_enable ? ((raw >> 1) ^ {WORD_W{raw[0]}}) : raw;

endmodule

[rtl/vqg_merge.sv]
// Merge stage: lane prefix sums, then the running delta against the stored
// previous value, and the output register. Depends on vqg_pkg, vqg_out_if.
module vqg_merge
	import vqg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             grp_valid,
	input  grp_t             grp,
	output logic             grp_ready,
	vqg_out_if.source        out_ch
);

	logic      v_s2;
	grp_t      grp_s2;
	lane_vec_t sum_s2;
	lane_vec_t sum_next;
	word_t     pair01;
	word_t     pair23;

	logic      out_v_q;
	lane_vec_t val_q;
	bytes_t    bytes_q;
	word_t     prev_q;

	lane_vec_t final_vals;
	word_t     base;
	logic      ready3;
	logic      load3;

	// prefix tree, two adders deep
	assign pair01 = grp.vals[0] + grp.vals[1];
	assign pair23 = grp.vals[2] + grp.vals[3];
	always_comb begin
		sum_next[0] = grp.vals[0];
		sum_next[1] = pair01;
		sum_next[2] = pair01 + grp.vals[2];
		sum_next[3] = pair01 + pair23;
	end

	assign ready3    = !out_v_q || out_ch.ready;
	assign grp_ready = !v_s2 || ready3;
	assign load3     = v_s2 && ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (grp_ready) begin
			v_s2 <= grp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_ready && grp_valid) begin
			grp_s2 <= grp;
			sum_s2 <= sum_next;
		end
	end

	// restart reseeds the running sum before this group
	assign base = grp_s2.restart ? cfg.delta_start : prev_q;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++)
			final_vals[i] = cfg.delta_enable ? (base + sum_s2[i]) : grp_s2.vals[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			prev_q  <= '0;
		end else begin
			if (ready3)
				out_v_q <= v_s2;
			if (load3)
				prev_q <= final_vals[NUM_LANES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			val_q   <= final_vals;
			bytes_q <= grp_s2.bytes_used;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.value0     = val_q[0];
	assign out_ch.value1     = val_q[1];
	assign out_ch.value2     = val_q[2];
	assign out_ch.value3     = val_q[3];
	assign out_ch.bytes_used = bytes_q;

	// previous value tracks the last value handed out
	a_prev_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load3 |=> (prev_q == val_q[NUM_LANES-1]))
		else $error("previous value does not follow last output");

	// a stalled group in stage 2 is kept
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ready3) |=> v_s2)
		else $error("stage 2 transaction lost under stall");

	// a loaded output register only appears from a full stage 2
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_v_q && !v_s2) |=> !out_v_q)
		else $error("output valid without source transaction");

endmodule

[rtl/varint_quad_group_decoder_top.sv]
// Top level of the four-value variable-length group decoder.
// Depends on vqg_pkg, vqg_in_if, vqg_out_if, vqg_lane, vqg_merge.
//
// Usage:
//   in_ch carries one group per transaction: key_byte (four 2-bit length
//   codes), a 16-byte window in data_low/data_high (byte 0 in bits 7:0) and
//   restart, which reseeds the running sum from delta_start.
//   out_ch returns one transaction per group: value0..value3 and bytes_used,
//   the number of window bytes the group consumed (0..16).
//   The config port writes length_mode, zigzag_enable, delta_enable and
//   delta_start (indexes 0..3) on any edge with cfg_we high; write only while
//   no transaction is in flight.
// Timing:
//   An accepted group passes the stage 1 register, stage 2 and the output register
//   before it is valid on out_ch. Lane decode feeds the stage 1 register at the
//   accepting edge, the prefix tree feeds stage 2, the delta add feeds the output
//   register. Throughput is one group per cycle unless out_ch stalls. The only loop
//   is the previous-value register around a single 32-bit adder in the last stage.
// Reset and stall:
//   arst_n clears all valid bits, the config registers and the previous value.
//   Each stage holds its transaction while the next is full and stalled, so
//   the input keeps accepting until all three stages are occupied.
module varint_quad_group_decoder_top
	import vqg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	vqg_in_if.sink               in_ch,
	vqg_out_if.source            out_ch
);

	cfg_t cfg_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LENGTH_MODE: cfg_q.length_mode   <= cfg_wdata[0];
				CFG_ZIGZAG:      cfg_q.zigzag_enable <= cfg_wdata[0];
				CFG_DELTA:       cfg_q.delta_enable  <= cfg_wdata[0];
				CFG_DELTA_START: cfg_q.delta_start   <= cfg_wdata;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// lane lengths and byte offsets
	len_t              len   [NUM_LANES];
	off_t              offset[NUM_LANES];
	bytes_t            bytes_total;
	logic [WIN_W-1:0]  window;
	lane_vec_t         lane_vals;

	assign window = {in_ch.data_high, in_ch.data_low};

	always_comb begin
		bytes_t pos;
		pos = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			len[i]    = byte_count(cfg_q.length_mode, in_ch.key_byte[2*i +: 2]);
			// at most 12 before the last lane, fits the offset width
			offset[i] = pos[OFF_W-1:0];
			pos       = pos + bytes_t'(len[i]);
		end
		bytes_total = pos;
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		vqg_lane u_lane (
			.window        (window),
			.offset        (offset[g]),
			.len           (len[g]),
			.zigzag_enable (cfg_q.zigzag_enable),
			.value         (lane_vals[g])
		);
	end

	// stage 1 register
	logic v_s1;
	grp_t grp_s1;
	logic grp_ready;

	assign in_ch.ready = !v_s1 || grp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			grp_s1.vals       <= lane_vals;
			grp_s1.bytes_used <= bytes_total;
			grp_s1.restart    <= in_ch.restart;
		end
	end

	vqg_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.grp_valid (v_s1),
		.grp       (grp_s1),
		.grp_ready (grp_ready),
		.out_ch    (out_ch)
	);

	// an accepted transaction always lands in stage 1
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> v_s1)
		else $error("accepted transaction not captured in stage 1");

	// a group never consumes more than the window
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (grp_s1.bytes_used <= bytes_t'(WIN_BYTES)))
		else $error("bytes used exceeds window size");

	// stalled stage 1 keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !grp_ready) |=> (v_s1 && $stable(grp_s1)))
		else $error("stage 1 transaction changed under stall");

endmodule
